FILE: src/lru_block_cache_directory_unit_macros.svh
// ============================================================================
// LRU block cache directory assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ============================================================================
`ifndef LRU_BLOCK_CACHE_DIRECTORY_UNIT_MACROS_SVH
`define LRU_BLOCK_CACHE_DIRECTORY_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LBCD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LBCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lbcd_pkg.sv
// ============================================================================
// LRU block cache directory package
// Sizes, slot entry type, status codes and controller states.
// ============================================================================
`default_nettype none

package lbcd_pkg;

	localparam int NUM_SLOTS = 8;
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CHAN_W = 16;
	localparam int BLOCK_W = 64;
	localparam int STAMP_W = 64;
	localparam int STATUS_W = 2;
	localparam int SLOT_FIELD_W = 3;

	localparam logic [STATUS_W-1:0] STATUS_HIT = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FILLED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_UNAVAIL = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FETCH_ERR = 2'd3;

	typedef logic [SLOT_W-1:0] slot_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] channel;
		logic [BLOCK_W-1:0] block;
		logic [STAMP_W-1:0] stamp;
	} slot_entry_t;

	typedef struct packed {
		logic hit;
		slot_idx_t hit_idx;
		slot_idx_t victim_idx;
	} scan_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DONE
	} state_t;

	function automatic logic [SLOT_FIELD_W-1:0] slot_field(input slot_idx_t idx);
		logic [SLOT_W+SLOT_FIELD_W-1:0] ext;
		ext = {{SLOT_FIELD_W{1'b0}}, idx};
		return ext[SLOT_FIELD_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: src/lbcd_slot_ram.sv
// ============================================================================
// Slot entry memory
// One write port and one read port, read data registered and available the cycle after the read.
// ============================================================================
`default_nettype none

module lbcd_slot_ram (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire lbcd_pkg::slot_idx_t  waddr,
	input  wire lbcd_pkg::slot_entry_t wdata,
	input  wire logic                 re,
	input  wire lbcd_pkg::slot_idx_t  raddr,
	output lbcd_pkg::slot_entry_t     rdata
);

	lbcd_pkg::slot_entry_t mem [lbcd_pkg::NUM_SLOTS];
	lbcd_pkg::slot_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: src/lbcd_lookup.sv
// ============================================================================
// Slot lookup tracker
// Compares one slot per cycle against the request while cmp_en is high and tracks the hit slot,
// the first empty slot and the oldest valid slot.
// ============================================================================
`default_nettype none

module lbcd_lookup (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          cmp_en,
	input  wire lbcd_pkg::slot_idx_t           cmp_idx,
	input  wire logic                          cmp_valid,
	input  wire lbcd_pkg::slot_entry_t         cmp_entry,
	input  wire logic [lbcd_pkg::CHAN_W-1:0]   req_channel,
	input  wire logic [lbcd_pkg::BLOCK_W-1:0]  req_block,
	output lbcd_pkg::scan_result_t             result
);

	logic hit_q;
	logic empty_q;
	logic best_q;
	lbcd_pkg::slot_idx_t hit_idx_q;
	lbcd_pkg::slot_idx_t empty_idx_q;
	lbcd_pkg::slot_idx_t best_idx_q;
	logic [lbcd_pkg::STAMP_W-1:0] best_stamp_q;
	logic match;
	logic older;

	assign match = cmp_valid && (cmp_entry.channel == req_channel)
		&& (cmp_entry.block == req_block);
	assign older = !best_q || (cmp_entry.stamp < best_stamp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
			empty_q <= 1'b0;
			best_q <= 1'b0;
		end else if (start) begin
			hit_q <= 1'b0;
			empty_q <= 1'b0;
			best_q <= 1'b0;
		end else if (cmp_en) begin
			if (match) begin
				hit_q <= 1'b1;
			end
			if (!cmp_valid) begin
				empty_q <= 1'b1;
			end
			if (cmp_valid) begin
				best_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			if (match && !hit_q) begin
				hit_idx_q <= cmp_idx;
			end
			if (!cmp_valid && !empty_q) begin
				empty_idx_q <= cmp_idx;
			end
			if (cmp_valid && older) begin
				best_idx_q <= cmp_idx;
				best_stamp_q <= cmp_entry.stamp;
			end
		end
	end

	always_comb begin
		result.hit = hit_q;
		result.hit_idx = hit_idx_q;
		result.victim_idx = empty_q ? empty_idx_q : best_idx_q;
	end

endmodule

`default_nettype wire

FILE: src/lru_block_cache_directory_unit.sv
// ============================================================================
// LRU block cache directory
// Fully associative directory of block slots with timestamp LRU replacement.
// ============================================================================
// One request is handled at a time and gives one result. The slot memory
// has a single read port, so the walk reads one slot entry per cycle, then
// the ST_LAST state finishes the last compare and, once the output register
// is free, the ST_DONE state writes back the slot, its valid bit and the use
// clock. The result sits in an output register, so a new request is taken
// while the previous result still waits for its transfer. Slot valid bits
// are cleared by reset, so no clearing pass is needed.
`default_nettype none
`include "lru_block_cache_directory_unit_macros.svh"

module lru_block_cache_directory_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [lbcd_pkg::CHAN_W-1:0]         channel,
	input  wire logic [lbcd_pkg::BLOCK_W-1:0]        block_num,
	input  wire logic                                indexed,
	input  wire logic                                backing_ready,
	input  wire logic                                fetch_ok,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [lbcd_pkg::STATUS_W-1:0]            status,
	output logic [lbcd_pkg::SLOT_FIELD_W-1:0]        slot
);

	localparam lbcd_pkg::slot_idx_t LAST_IDX = lbcd_pkg::SLOT_W'(lbcd_pkg::NUM_SLOTS - 1);

	lbcd_pkg::state_t state_q;
	lbcd_pkg::state_t state_nxt;

	logic [lbcd_pkg::CHAN_W-1:0] ch_q;
	logic [lbcd_pkg::BLOCK_W-1:0] blk_q;
	logic indexed_q;
	logic ready_q;
	logic ok_q;

	lbcd_pkg::slot_idx_t rd_cnt_q;
	logic cmp_vld_s1;
	lbcd_pkg::slot_idx_t cmp_idx_s1;

	logic [lbcd_pkg::NUM_SLOTS-1:0] slot_valid_q;
	logic [lbcd_pkg::STAMP_W-1:0] use_clock_q;
	logic [lbcd_pkg::STAMP_W-1:0] use_clock_inc;

	logic out_valid_q;
	logic [lbcd_pkg::STATUS_W-1:0] status_q;
	logic [lbcd_pkg::SLOT_FIELD_W-1:0] slot_q;

	logic in_fire;
	logic out_free;
	logic rd_en;
	logic done_fire;

	lbcd_pkg::slot_entry_t rd_entry;
	lbcd_pkg::slot_entry_t wr_entry;
	lbcd_pkg::scan_result_t scan;
	logic wr_en;
	lbcd_pkg::slot_idx_t wr_idx;
	logic [lbcd_pkg::STATUS_W-1:0] res_status;
	lbcd_pkg::slot_idx_t res_idx;
	logic set_valid;
	logic clr_valid;
	logic bump_clock;

	assign in_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign use_clock_inc = use_clock_q + lbcd_pkg::STAMP_W'(1);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			lbcd_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = lbcd_pkg::ST_SCAN;
				end
			end
			lbcd_pkg::ST_SCAN: begin
				if (rd_cnt_q == LAST_IDX) begin
					state_nxt = lbcd_pkg::ST_LAST;
				end
			end
			lbcd_pkg::ST_LAST: begin
				state_nxt = lbcd_pkg::ST_DONE;
			end
			lbcd_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = lbcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = lbcd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = (state_q == lbcd_pkg::ST_IDLE);
		rd_en = (state_q == lbcd_pkg::ST_SCAN);
		done_fire = (state_q == lbcd_pkg::ST_DONE) && out_free;
	end

	always_comb begin
		res_status = lbcd_pkg::STATUS_UNAVAIL;
		res_idx = '0;
		wr_en = 1'b0;
		wr_idx = scan.victim_idx;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		bump_clock = 1'b0;
		if (scan.hit) begin
			res_status = lbcd_pkg::STATUS_HIT;
			res_idx = scan.hit_idx;
			wr_en = done_fire;
			wr_idx = scan.hit_idx;
			bump_clock = done_fire;
		end else if (indexed_q && ready_q) begin
			res_idx = scan.victim_idx;
			wr_en = done_fire;
			if (ok_q) begin
				res_status = lbcd_pkg::STATUS_FILLED;
				set_valid = done_fire;
				bump_clock = done_fire;
			end else begin
				res_status = lbcd_pkg::STATUS_FETCH_ERR;
				clr_valid = done_fire;
			end
		end
		wr_entry.channel = ch_q;
		wr_entry.block = blk_q;
		wr_entry.stamp = use_clock_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbcd_pkg::ST_IDLE;
			rd_cnt_q <= '0;
			cmp_vld_s1 <= 1'b0;
			slot_valid_q <= '0;
			use_clock_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			cmp_vld_s1 <= rd_en;
			if (in_fire) begin
				rd_cnt_q <= '0;
			end else if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + lbcd_pkg::SLOT_W'(1);
			end
			if (set_valid) begin
				slot_valid_q[wr_idx] <= 1'b1;
			end else if (clr_valid) begin
				slot_valid_q[wr_idx] <= 1'b0;
			end
			if (bump_clock) begin
				use_clock_q <= use_clock_inc;
			end
			if (done_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= channel;
			blk_q <= block_num;
			indexed_q <= indexed;
			ready_q <= backing_ready;
			ok_q <= fetch_ok;
		end
		cmp_idx_s1 <= rd_cnt_q;
		if (done_fire) begin
			status_q <= res_status;
			slot_q <= lbcd_pkg::slot_field(res_idx);
		end
	end

	lbcd_slot_ram u_slot_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_idx),
		.wdata (wr_entry),
		.re    (rd_en),
		.raddr (rd_cnt_q),
		.rdata (rd_entry)
	);

	lbcd_lookup u_lookup (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_fire),
		.cmp_en      (cmp_vld_s1),
		.cmp_idx     (cmp_idx_s1),
		.cmp_valid   (slot_valid_q[cmp_idx_s1]),
		.cmp_entry   (rd_entry),
		.req_channel (ch_q),
		.req_block   (blk_q),
		.result      (scan)
	);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot = slot_q;

	`LBCD_ASSERT_NEXT(a_accept_starts_scan, in_fire, state_q == lbcd_pkg::ST_SCAN, "transfer in did not start a scan")
	`LBCD_ASSERT_SAME(a_compare_in_walk, cmp_vld_s1, (state_q == lbcd_pkg::ST_SCAN) || (state_q == lbcd_pkg::ST_LAST), "slot compare outside the walk")
	`LBCD_ASSERT_NEXT(a_done_loads_result, done_fire, out_valid_q && (state_q == lbcd_pkg::ST_IDLE), "finished request did not load a result")
	`LBCD_ASSERT_NEXT(a_clock_only_at_done, state_q != lbcd_pkg::ST_DONE, $stable(use_clock_q), "use clock moved outside write-back")

endmodule

`default_nettype wire
